@@ rtl/esc_pkg.sv @@
// Package for the epoch seconds to calendar unit: constants, command and status
// types, and the calendar helper functions.
// No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

  // Divisors for the day, hour and minute splits
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [10:0] BASE_YEAR = 11'd1904;

  // Reciprocals floor(2^k / d) on the pre-shifted dividend; the estimate is low
  // by at most one and the fix-up step adds it back.
  localparam logic [15:0] DAY_RECIP  = 16'd49710;  // (secs >> 7) / 675, k = 25
  localparam logic [5:0]  HOUR_RECIP = 6'd36;      // (tod >> 4) / 225, k = 13
  localparam logic [6:0]  MIN_RECIP  = 7'd68;      // (rem >> 2) / 15,  k = 10

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_SEL_DAY  = 2'd0;
  localparam div_sel_t DIV_SEL_HOUR = 2'd1;
  localparam div_sel_t DIV_SEL_MIN  = 2'd2;

  typedef struct packed {
    logic     load_in;
    logic     div_est;
    logic     div_rem;
    logic     div_fix;
    div_sel_t div_sel;
    logic     year_step;
    logic     month_step;
    logic     load_out;
  } esc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } esc_status_t;

  // Years reachable are 1904..2040; the only century year among them is 2000,
  // a multiple of 400, so divisibility by 4 gives the full Gregorian rule.
  function automatic logic leap_year(input logic [10:0] y);
    leap_year = (y[1:0] == 2'b00);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    year_len = leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

@@ rtl/esc_ctrl.sv @@
// Controller for the epoch seconds to calendar unit: sequences the divide
// steps, the year and month walks and the output hand-off.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_ctrl
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  esc_status_t status,
  output esc_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DAY_EST  = 4'd1;
  localparam logic [3:0] ST_DAY_REM  = 4'd2;
  localparam logic [3:0] ST_DAY_FIX  = 4'd3;
  localparam logic [3:0] ST_HOUR_EST = 4'd4;
  localparam logic [3:0] ST_HOUR_REM = 4'd5;
  localparam logic [3:0] ST_HOUR_FIX = 4'd6;
  localparam logic [3:0] ST_MIN_EST  = 4'd7;
  localparam logic [3:0] ST_MIN_REM  = 4'd8;
  localparam logic [3:0] ST_MIN_FIX  = 4'd9;
  localparam logic [3:0] ST_YEAR     = 4'd10;
  localparam logic [3:0] ST_MONTH    = 4'd11;
  localparam logic [3:0] ST_EMIT     = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DAY_EST;
        end
      end
      ST_DAY_EST: begin
        cmd.div_est = 1'b1;
        cmd.div_sel = DIV_SEL_DAY;
        state_nxt   = ST_DAY_REM;
      end
      ST_DAY_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_sel = DIV_SEL_DAY;
        state_nxt   = ST_DAY_FIX;
      end
      ST_DAY_FIX: begin
        cmd.div_fix = 1'b1;
        cmd.div_sel = DIV_SEL_DAY;
        state_nxt   = ST_HOUR_EST;
      end
      ST_HOUR_EST: begin
        cmd.div_est = 1'b1;
        cmd.div_sel = DIV_SEL_HOUR;
        state_nxt   = ST_HOUR_REM;
      end
      ST_HOUR_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_sel = DIV_SEL_HOUR;
        state_nxt   = ST_HOUR_FIX;
      end
      ST_HOUR_FIX: begin
        cmd.div_fix = 1'b1;
        cmd.div_sel = DIV_SEL_HOUR;
        state_nxt   = ST_MIN_EST;
      end
      ST_MIN_EST: begin
        cmd.div_est = 1'b1;
        cmd.div_sel = DIV_SEL_MIN;
        state_nxt   = ST_MIN_REM;
      end
      ST_MIN_REM: begin
        cmd.div_rem = 1'b1;
        cmd.div_sel = DIV_SEL_MIN;
        state_nxt   = ST_MIN_FIX;
      end
      ST_MIN_FIX: begin
        cmd.div_fix = 1'b1;
        cmd.div_sel = DIV_SEL_MIN;
        state_nxt   = ST_YEAR;
      end
      ST_YEAR: begin
        cmd.year_step = 1'b1;
        if (status.year_done) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (status.month_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/esc_dpath.sv @@
// Datapath for the epoch seconds to calendar unit: reciprocal-multiply divide
// steps, year and month subtractors, and the output register.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_dpath
  import esc_pkg::*;
(
  input  logic        clk,
  input  esc_cmd_t    cmd,
  output esc_status_t status,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_is_blank,
  output logic [10:0] out_year,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_hour_twelve,
  output logic        out_is_pm,
  output logic [5:0]  out_minute
);

  logic [31:0] secs_r;
  logic        blank_r;
  logic [15:0] days_r;
  logic [17:0] tod_r;     // below two days until the fix-up
  logic [4:0]  hour_r;
  logic [12:0] hrem_r;    // below two hours until the fix-up
  logic [5:0]  minute_r;
  logic [6:0]  mrem_r;    // below two minutes
  logic [10:0] year_r;
  logic [3:0]  month_r;

  logic        blank_out_r;
  logic [10:0] year_out_r;
  logic [3:0]  month_out_r;
  logic [4:0]  day_out_r;
  logic [3:0]  h12_out_r;
  logic        pm_out_r;
  logic [5:0]  minute_out_r;

  logic [40:0] day_prod;
  logic [17:0] hour_prod;
  logic [15:0] min_prod;
  logic [31:0] day_back;
  logic [16:0] hour_back;
  logic [11:0] min_back;
  logic [31:0] day_rem;
  logic [16:0] hour_rem;
  logic [11:0] min_rem;
  logic        day_over;
  logic        hour_over;
  logic        min_over;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        is_pm;
  logic [4:0]  h_mod;
  logic [3:0]  h12;

  // quotient estimates
  assign day_prod  = 41'(secs_r[31:7]) * 41'(DAY_RECIP);
  assign hour_prod = 18'(tod_r[16:4]) * 18'(HOUR_RECIP);
  assign min_prod  = 16'(hrem_r[11:2]) * 16'(MIN_RECIP);

  // remainders against the estimates
  assign day_back  = 32'(days_r) * 32'(SECS_PER_DAY);
  assign hour_back = 17'(hour_r) * SECS_PER_HOUR;
  assign min_back  = 12'(minute_r) * 12'(SECS_PER_MIN);
  assign day_rem   = secs_r - day_back;
  assign hour_rem  = tod_r[16:0] - hour_back;
  assign min_rem   = hrem_r[11:0] - min_back;

  assign day_over  = (tod_r >= {1'b0, SECS_PER_DAY});
  assign hour_over = (hrem_r >= 13'(SECS_PER_HOUR));
  assign min_over  = (mrem_r >= 7'(SECS_PER_MIN));

  assign leap = leap_year(year_r);
  assign ylen = year_len(leap);
  assign mlen = month_len(month_r, leap);

  assign status.year_done  = (days_r < {7'd0, ylen});
  assign status.month_done = (days_r < {11'd0, mlen}) || (month_r >= 4'd11);

  assign is_pm = (hour_r >= 5'd12);
  assign h_mod = is_pm ? 5'(hour_r - 5'd12) : hour_r;
  assign h12   = (h_mod == 5'd0) ? 4'd12 : h_mod[3:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      secs_r  <= in_epoch_seconds;
      blank_r <= (in_epoch_seconds == 32'd0);
      year_r  <= BASE_YEAR;
      month_r <= '0;
    end else if (cmd.div_est) begin
      unique case (cmd.div_sel)
        DIV_SEL_DAY:  days_r   <= day_prod[40:25];
        DIV_SEL_HOUR: hour_r   <= hour_prod[17:13];
        default:      minute_r <= min_prod[15:10];
      endcase
    end else if (cmd.div_rem) begin
      unique case (cmd.div_sel)
        DIV_SEL_DAY:  tod_r  <= day_rem[17:0];
        DIV_SEL_HOUR: hrem_r <= hour_rem[12:0];
        default:      mrem_r <= min_rem[6:0];
      endcase
    end else if (cmd.div_fix) begin
      unique case (cmd.div_sel)
        DIV_SEL_DAY: begin
          if (day_over) begin
            tod_r  <= tod_r - {1'b0, SECS_PER_DAY};
            days_r <= days_r + 16'd1;
          end
        end
        DIV_SEL_HOUR: begin
          if (hour_over) begin
            hrem_r <= hrem_r - 13'(SECS_PER_HOUR);
            hour_r <= hour_r + 5'd1;
          end
        end
        default: begin
          if (min_over) begin
            minute_r <= minute_r + 6'd1;
          end
        end
      endcase
    end else if (cmd.year_step) begin
      if (!status.year_done) begin
        days_r <= days_r - {7'd0, ylen};
        year_r <= year_r + 11'd1;
      end
    end else if (cmd.month_step) begin
      if (!status.month_done) begin
        days_r  <= days_r - {11'd0, mlen};
        month_r <= month_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      blank_out_r  <= blank_r;
      year_out_r   <= year_r;
      month_out_r  <= month_r;
      day_out_r    <= 5'(days_r[4:0] + 5'd1);
      h12_out_r    <= h12;
      pm_out_r     <= is_pm;
      minute_out_r <= minute_r;
    end
  end

  assign out_is_blank     = blank_out_r;
  assign out_year         = year_out_r;
  assign out_month_index  = month_out_r;
  assign out_day_of_month = day_out_r;
  assign out_hour_twelve  = h12_out_r;
  assign out_is_pm        = pm_out_r;
  assign out_minute       = minute_out_r;

endmodule

@@ rtl/epoch_seconds_to_calendar_unit.sv @@
// Epoch seconds to calendar unit: 1904-based second count to Gregorian date
// and 12-hour time. Top level joining the controller and the datapath.
// Depends on esc_pkg, esc_ctrl and esc_dpath.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_epoch_seconds): one request carries a
//    32-bit unsigned second count. in_ready is high only while the unit is
//    idle; one request is in work at a time.
//  - Result channel (out_valid/out_ready/out_*): one result per request.
//    Fields sit in an output register, so a result may wait for the receiver
//    while the next request is already accepted and worked on.
//  - Sequence: after acceptance, day, hour and minute each go through a
//    reciprocal estimate, a back-multiply and a one-step fix-up; then the
//    year walk steps one year at a time and the month walk one month at a
//    time, each until its status reports done; then the hand-off to the
//    output register.
//  - A new request is taken only once the previous one is handed off.
//  - Receiver stall: a finished request holds in the last step until the
//    output register is free, then in_ready returns.
//  - Reset (rst_n low, synchronous): controller returns to idle, out_valid
//    drops; payload registers are not cleared.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_blank,
  output logic [10:0] out_year,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_hour_twelve,
  output logic        out_is_pm,
  output logic [5:0]  out_minute
);

  // command and status between the state machine and the datapath
  esc_cmd_t    cmd;
  esc_status_t status;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  esc_dpath u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .in_epoch_seconds (in_epoch_seconds),
    .out_is_blank     (out_is_blank),
    .out_year         (out_year),
    .out_month_index  (out_month_index),
    .out_day_of_month (out_day_of_month),
    .out_hour_twelve  (out_hour_twelve),
    .out_is_pm        (out_is_pm),
    .out_minute       (out_minute)
  );

endmodule
